[src/rk4u_pkg.sv]
// ----------------------------------------------------------------------------
// rk4u_pkg
// Shared constants, types and helpers for the rk4 stage update pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rk4u_pkg;

    localparam int unsigned DEPTH  = 256;
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned DT_W   = 31;
    localparam int unsigned SUM_W  = 35;   // k1 + 2k2 + 2k3 + k4
    localparam int unsigned MAG_W  = 48;   // scaled increment magnitude
    localparam int unsigned SAT_W  = 50;   // base +/- increment
    localparam int unsigned PL_W   = DT_W + VAL_W;
    localparam int unsigned PH_W   = DT_W + SUM_W - VAL_W;

    // pipeline stage map
    localparam int unsigned PREFIX_STEPS = 5;
    localparam int unsigned ST_SCALE     = 2;
    localparam int unsigned ST_DIV       = 6;
    localparam int unsigned ST_OUT       = 13;
    localparam int unsigned STAGES       = 13;

    localparam logic [DT_W-1:0] DT_RESET = 31'd65536;

    localparam logic [2:0] OP_STAGE1 = 3'd1;
    localparam logic [2:0] OP_STAGE2 = 3'd2;
    localparam logic [2:0] OP_STAGE3 = 3'd3;
    localparam logic [2:0] OP_STAGE4 = 3'd4;

    localparam logic [MAG_W-1:0] EVEN_MASK = 48'h5555_5555_5555;
    localparam logic [MAG_W-1:0] ODD_MASK  = 48'hAAAA_AAAA_AAAA;

    localparam logic signed [SAT_W-1:0] POS_MAX =
        {{(SAT_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] NEG_MIN = ~POS_MAX;

    typedef struct packed {
        logic [2:0]              op;
        logic                    neg;
        logic signed [VAL_W-1:0] base;
    } t_tag;

    typedef struct packed {
        logic signed [VAL_W-1:0] start;
        logic signed [VAL_W-1:0] k1;
        logic signed [VAL_W-1:0] k2;
        logic signed [VAL_W-1:0] k3;
    } t_store_rd;

    // n mod 3: base-4 digits are each worth 1 mod 3
    function automatic logic [1:0] mod3(input logic [MAG_W-1:0] n);
        logic [4:0] ev;
        logic [4:0] od;
        logic [6:0] t;
        logic [3:0] u;
        logic [2:0] w;
        logic [1:0] r;
        ev = 5'($countones(n & EVEN_MASK));
        od = 5'($countones(n & ODD_MASK));
        t  = {2'b00, ev} + {1'b0, od, 1'b0};
        u  = {2'b00, t[1:0]} + {2'b00, t[3:2]} + {2'b00, t[5:4]} + {3'b000, t[6]};
        w  = {1'b0, u[1:0]} + {1'b0, u[3:2]};
        if (w >= 3'd6) begin
            r = 2'd0;
        end else if (w >= 3'd3) begin
            r = 2'(w - 3'd3);
        end else begin
            r = w[1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/rk4_ode_stage_update_unit.sv]
// ----------------------------------------------------------------------------
// rk4_ode_stage_update_unit
// Per-element RK4 stage update with saturated Q16.16 result.
// Throughput: one word per cycle; a 13-stage pipeline where each stage
// holds only while it is full and the stage after it cannot move.
// Reset (synchronous, active low) empties the pipeline and sets dt to 1.0;
// the element stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4_ode_stage_update_unit
    import rk4u_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [DT_W-1:0]         i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [2:0]              i_op,
    input  wire logic [IDX_W-1:0]        i_element_index,
    input  wire logic signed [VAL_W-1:0] i_derivative,
    input  wire logic signed [VAL_W-1:0] i_position_in,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [VAL_W-1:0]      o_position_out,
    output logic                         o_full_step
);

    logic [DT_W-1:0]         r_time_step;
    logic [STAGES:1]         r_valid;
    logic [STAGES:1]         n_valid;
    logic [STAGES:1]         adv;
    logic                    all_full;
    logic                    accept;

    logic [2:0]              st_op;
    logic signed [VAL_W-1:0] st_v;
    logic signed [VAL_W-1:0] st_x;
    t_store_rd               st_rd;
    t_tag                    sc_tag;
    logic [MAG_W-1:0]        sc_val;
    t_tag                    dv_tag;
    logic [MAG_W-1:0]        dv_mag;

    logic signed [SAT_W-1:0] ext_base;
    logic signed [SAT_W-1:0] ext_mag;
    logic signed [SAT_W-1:0] sum;
    logic signed [VAL_W-1:0] n_pos_out;
    logic                    n_full_step;
    logic signed [VAL_W-1:0] r_pos_out;
    logic                    r_full_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= DT_RESET;
        end else if (i_cfg_we) begin
            r_time_step <= i_cfg_data;
        end
    end

    // a stage moves unless it and every stage after it are full and stalled
    always_comb begin
        all_full = 1'b1;
        for (int k = STAGES; k >= 1; k--) begin
            all_full = all_full & r_valid[k];
            adv[k]   = ~(all_full & i_stall);
        end
    end

    assign n_valid = {r_valid[STAGES-1:1], i_valid};
    assign accept  = i_valid & adv[1];
    assign o_stall = ~adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 1; k <= STAGES; k++) begin
                if (adv[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    rk4u_store u_store (
        .i_clk (i_clk),
        .i_we  (accept),
        .i_adv (adv[1]),
        .i_op  (i_op),
        .i_idx (i_element_index),
        .i_v   (i_derivative),
        .i_x   (i_position_in),
        .o_op  (st_op),
        .o_v   (st_v),
        .o_x   (st_x),
        .o_rd  (st_rd)
    );

    rk4u_scale u_scale (
        .i_clk (i_clk),
        .i_adv (adv[ST_DIV-1:ST_SCALE]),
        .i_dt  (r_time_step),
        .i_op  (st_op),
        .i_v   (st_v),
        .i_x   (st_x),
        .i_rd  (st_rd),
        .o_tag (sc_tag),
        .o_val (sc_val)
    );

    rk4u_div3 u_div3 (
        .i_clk (i_clk),
        .i_adv (adv[ST_OUT-1:ST_DIV]),
        .i_tag (sc_tag),
        .i_val (sc_val),
        .o_tag (dv_tag),
        .o_mag (dv_mag)
    );

    // final stage: apply sign, add to base and clamp
    assign ext_base = SAT_W'(dv_tag.base);
    assign ext_mag  = $signed({{(SAT_W-MAG_W){1'b0}}, dv_mag});
    assign sum      = dv_tag.neg ? ext_base - ext_mag : ext_base + ext_mag;

    always_comb begin
        if (sum > POS_MAX) begin
            n_pos_out = VAL_W'(POS_MAX);
        end else if (sum < NEG_MIN) begin
            n_pos_out = VAL_W'(NEG_MIN);
        end else begin
            n_pos_out = sum[VAL_W-1:0];
        end
        case (dv_tag.op)
            OP_STAGE1, OP_STAGE2: begin
                n_full_step = 1'b0;
            end
            default: begin
                n_full_step = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_OUT]) begin
            r_pos_out   <= n_pos_out;
            r_full_step <= n_full_step;
        end
    end

    assign o_valid        = r_valid[STAGES];
    assign o_position_out = r_pos_out;
    assign o_full_step    = r_full_step;

endmodule

`default_nettype wire

[src/rk4u_store.sv]
// ----------------------------------------------------------------------------
// rk4u_store
// Input capture and per-element stores for x0, k1, k2 and k3.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4u_store
    import rk4u_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic                    i_adv,
    input  wire logic [2:0]              i_op,
    input  wire logic [IDX_W-1:0]        i_idx,
    input  wire logic signed [VAL_W-1:0] i_v,
    input  wire logic signed [VAL_W-1:0] i_x,
    output logic [2:0]                   o_op,
    output logic signed [VAL_W-1:0]      o_v,
    output logic signed [VAL_W-1:0]      o_x,
    output t_store_rd                    o_rd
);

    logic signed [VAL_W-1:0] r_start_value [DEPTH];
    logic signed [VAL_W-1:0] r_slope_one   [DEPTH];
    logic signed [VAL_W-1:0] r_slope_two   [DEPTH];
    logic signed [VAL_W-1:0] r_slope_three [DEPTH];

    logic signed [VAL_W-1:0] r_rd_start;
    logic signed [VAL_W-1:0] r_rd_k1;
    logic signed [VAL_W-1:0] r_rd_k2;
    logic signed [VAL_W-1:0] r_rd_k3;
    logic [2:0]              r_op;
    logic signed [VAL_W-1:0] r_v;
    logic signed [VAL_W-1:0] r_x;

    // read-before-write: a word sees every store made by earlier words
    always_ff @(posedge i_clk) begin
        if (i_we && i_op == OP_STAGE1) begin
            r_start_value[i_idx] <= i_x;
        end
        if (i_adv) begin
            r_rd_start <= r_start_value[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && i_op == OP_STAGE1) begin
            r_slope_one[i_idx] <= i_v;
        end
        if (i_adv) begin
            r_rd_k1 <= r_slope_one[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && i_op == OP_STAGE2) begin
            r_slope_two[i_idx] <= i_v;
        end
        if (i_adv) begin
            r_rd_k2 <= r_slope_two[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && i_op == OP_STAGE3) begin
            r_slope_three[i_idx] <= i_v;
        end
        if (i_adv) begin
            r_rd_k3 <= r_slope_three[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_op <= i_op;
            r_v  <= i_v;
            r_x  <= i_x;
        end
    end

    assign o_op       = r_op;
    assign o_v        = r_v;
    assign o_x        = r_x;
    assign o_rd.start = r_rd_start;
    assign o_rd.k1    = r_rd_k1;
    assign o_rd.k2    = r_rd_k2;
    assign o_rd.k3    = r_rd_k3;

endmodule

`default_nettype wire

[src/rk4u_scale.sv]
// ----------------------------------------------------------------------------
// rk4u_scale
// Slope sum, magnitude, dt multiply and rounding of the increment.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4u_scale
    import rk4u_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic [3:0]              i_adv,
    input  wire logic [DT_W-1:0]         i_dt,
    input  wire logic [2:0]              i_op,
    input  wire logic signed [VAL_W-1:0] i_v,
    input  wire logic signed [VAL_W-1:0] i_x,
    input  wire t_store_rd               i_rd,
    output t_tag                         o_tag,
    output logic [MAG_W-1:0]             o_val
);

    logic signed [SUM_W-1:0] r2_sum;
    logic signed [VAL_W-1:0] r2_v;
    t_tag                    r2_tag;
    t_tag                    n2_tag;

    t_tag                    r3_tag;
    t_tag                    n3_tag;
    logic [SUM_W-1:0]        r3_a;
    logic [SUM_W-1:0]        n3_a;
    logic [VAL_W-1:0]        v_mag;

    t_tag                    r4_tag;
    logic [PL_W-1:0]         r4_pl;
    logic [PH_W-1:0]         r4_ph;

    t_tag                    r5_tag;
    logic [MAG_W-1:0]        r5_val;
    logic [MAG_W-1:0]        n5_val;
    logic [PL_W:0]           half_sum;
    logic [PL_W:0]           full_sum;
    logic [SAT_W-1:0]        q_sum;

    // stage 2: weighted slope sum and base selection
    always_comb begin
        n2_tag      = '0;
        n2_tag.op   = i_op;
        case (i_op)
            OP_STAGE2, OP_STAGE3, OP_STAGE4: begin
                n2_tag.base = i_rd.start;
            end
            default: begin
                n2_tag.base = i_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r2_sum <= SUM_W'(i_rd.k1) + (SUM_W'(i_rd.k2) <<< 1)
                    + (SUM_W'(i_rd.k3) <<< 1) + SUM_W'(i_v);
            r2_v   <= i_v;
            r2_tag <= n2_tag;
        end
    end

    // stage 3: sign and magnitude of the multiplicand
    assign v_mag = r2_v[VAL_W-1] ? $unsigned(-r2_v) : $unsigned(r2_v);

    always_comb begin
        n3_tag     = r2_tag;
        n3_tag.neg = 1'b0;
        n3_a       = '0;
        case (r2_tag.op)
            OP_STAGE1, OP_STAGE2, OP_STAGE3: begin
                n3_tag.neg = r2_v[VAL_W-1];
                n3_a       = SUM_W'(v_mag);
            end
            OP_STAGE4: begin
                n3_tag.neg = r2_sum[SUM_W-1];
                n3_a       = r2_sum[SUM_W-1] ? $unsigned(-r2_sum) : $unsigned(r2_sum);
            end
            default: begin
                n3_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r3_tag <= n3_tag;
            r3_a   <= n3_a;
        end
    end

    // stage 4: dt times magnitude, split at bit 32
    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            r4_tag <= r3_tag;
            r4_pl  <= PL_W'(i_dt) * PL_W'(r3_a[VAL_W-1:0]);
            r4_ph  <= PH_W'(i_dt) * PH_W'(r3_a[SUM_W-1:VAL_W]);
        end
    end

    // stage 5: round half away on the magnitude; for the last stage form
    // (floor(p / 2^16) + 3) / 2, still to be divided by 3
    assign half_sum = {1'b0, r4_pl} + (PL_W+1)'(64'h1_0000);
    assign full_sum = {1'b0, r4_pl} + (PL_W+1)'(64'h8000);
    assign q_sum    = (SAT_W'(r4_ph) << 16) + SAT_W'(r4_pl >> 16) + SAT_W'(3);

    always_comb begin
        case (r4_tag.op)
            OP_STAGE1, OP_STAGE2: begin
                n5_val = MAG_W'(half_sum >> 17);
            end
            OP_STAGE3: begin
                n5_val = MAG_W'(full_sum >> 16);
            end
            OP_STAGE4: begin
                n5_val = q_sum[MAG_W:1];
            end
            default: begin
                n5_val = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[3]) begin
            r5_tag <= r4_tag;
            r5_val <= n5_val;
        end
    end

    assign o_tag = r5_tag;
    assign o_val = r5_val;

endmodule

`default_nettype wire

[src/rk4u_div3.sv]
// ----------------------------------------------------------------------------
// rk4u_div3
// Exact division by three: remove n mod 3, then multiply by the inverse of
// three modulo 2^48 through a chain of shift-and-add stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4u_div3
    import rk4u_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic [PREFIX_STEPS+1:0]   i_adv,
    input  wire t_tag                      i_tag,
    input  wire logic [MAG_W-1:0]          i_val,
    output t_tag                           o_tag,
    output logic [MAG_W-1:0]               o_mag
);

    logic [MAG_W-1:0] r_y   [PREFIX_STEPS+1];
    t_tag             r_tag [PREFIX_STEPS+1];
    logic [MAG_W-1:0] r_mag;
    t_tag             r_tag_out;

    // stage 6: make the dividend a multiple of three
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_tag[0] <= i_tag;
            if (i_tag.op == OP_STAGE4) begin
                r_y[0] <= i_val - MAG_W'(mod3(i_val));
            end else begin
                r_y[0] <= i_val;
            end
        end
    end

    // stages 7..11: y * (1 + 4)(1 + 4^2)(1 + 4^4)(1 + 4^8)(1 + 4^16)
    for (genvar g = 0; g < PREFIX_STEPS; g++) begin : g_prefix
        always_ff @(posedge i_clk) begin
            if (i_adv[g+1]) begin
                r_tag[g+1] <= r_tag[g];
                if (r_tag[g].op == OP_STAGE4) begin
                    r_y[g+1] <= r_y[g] + (r_y[g] << (2 << g));
                end else begin
                    r_y[g+1] <= r_y[g];
                end
            end
        end
    end

    // stage 12: 0x5555..5 is minus one third, so negate
    always_ff @(posedge i_clk) begin
        if (i_adv[PREFIX_STEPS+1]) begin
            r_tag_out <= r_tag[PREFIX_STEPS];
            if (r_tag[PREFIX_STEPS].op == OP_STAGE4) begin
                r_mag <= MAG_W'(0) - r_y[PREFIX_STEPS];
            end else begin
                r_mag <= r_y[PREFIX_STEPS];
            end
        end
    end

    assign o_tag = r_tag_out;
    assign o_mag = r_mag;

endmodule

`default_nettype wire

[tb/sv/tb_rk4_ode_stage_update_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rk4_ode_stage_update_unit
// Drives per-element RK4 stage words through the stage update unit. Every
// accepted word is run through a local model of the four stages, so the
// expected position and step flag are known ahead of time. Each result word
// is then compared field by field, in order.
// Directed checks come first: pass-through ops, saturation, back-to-back
// stages on one element, rounding ties and the time step extremes. After
// that come random phases of well-formed RK4 steps mixed with noise, each
// phase at its own time step. Sides idle at random but for back-to-back.
// ----------------------------------------------------------------------------

module tb_rk4_ode_stage_update_unit
    import rk4u_pkg::*;
();

    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned TAIL_CYCLES  = 40;
    localparam int unsigned REPORT_CAP   = 100;
    localparam int unsigned RANDOM_WORDS = 1500;
    localparam int unsigned PHASES       = 6;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [DT_W-1:0]         DT_MAX  = {DT_W{1'b1}};

    typedef struct {
        logic signed [VAL_W-1:0] position;
        logic                    full_step;
        logic [2:0]              op;
        logic [IDX_W-1:0]        index;
    } t_stage_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [DT_W-1:0]         i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    logic [2:0]              i_op;
    logic [IDX_W-1:0]        i_element_index;
    logic signed [VAL_W-1:0] i_derivative;
    logic signed [VAL_W-1:0] i_position_in;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [VAL_W-1:0] o_position_out;
    logic                    o_full_step;

    // model state
    logic [DT_W-1:0]         dt_model;
    logic signed [VAL_W-1:0] x0_mem [DEPTH];
    logic signed [VAL_W-1:0] k1_mem [DEPTH];
    logic signed [VAL_W-1:0] k2_mem [DEPTH];
    logic signed [VAL_W-1:0] k3_mem [DEPTH];
    logic                    x0_seen [DEPTH];
    logic                    k2_seen [DEPTH];
    logic                    k3_seen [DEPTH];

    t_stage_result expected_updates [$];
    int unsigned   error_count = 0;
    int unsigned   words_sent  = 0;
    int unsigned   stall_left  = 0;
    logic          src_gaps_on    = 1'b1;
    logic          sink_stalls_on = 1'b1;

    rk4_ode_stage_update_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_element_index (i_element_index),
        .i_derivative    (i_derivative),
        .i_position_in   (i_position_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_position_out  (o_position_out),
        .o_full_step     (o_full_step)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // stage arithmetic
    // ------------------------------------------------------------------------
    function automatic logic [63:0] magnitude_of(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // round(dt * mag / 2^shift), ties away from zero
    function automatic logic [63:0] scale_by_dt(input logic [63:0] mag,
                                                input int unsigned shift);
        logic [63:0] p;
        p = 64'(dt_model) * mag;
        return (p + (64'd1 << (shift - 1))) >> shift;
    endfunction

    // dt * mag / (6 * 2^16): truncate the 2^16 part, then round the sixth
    function automatic logic [63:0] sixth_by_dt(input logic [63:0] mag);
        logic [127:0] p;
        p = 128'(dt_model) * 128'(mag);
        p = p >> 16;
        return 64'((p + 128'd3) / 128'd6);
    endfunction

    function automatic logic signed [VAL_W-1:0] apply_increment(input longint base,
                                                                input logic neg,
                                                                input logic [63:0] mag);
        longint hi;
        longint lo;
        longint r;
        logic [63:0] m;
        hi = (longint'(1) <<< (VAL_W - 1)) - 1;
        lo = -hi - 1;
        m  = (mag > 64'h3FFF_FFFF_FFFF_FFFF) ? 64'h3FFF_FFFF_FFFF_FFFF : mag;
        r  = neg ? base - $signed(m) : base + $signed(m);
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return VAL_W'(r);
    endfunction

    function automatic t_stage_result predict_update(input logic [2:0] op,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic signed [VAL_W-1:0] slope,
                                                     input logic signed [VAL_W-1:0] pos);
        t_stage_result r;
        longint        sum;
        r.op        = op;
        r.index     = idx;
        r.position  = pos;
        r.full_step = 1'b1;
        case (op)
            OP_STAGE1: begin
                x0_mem[idx]  = pos;
                k1_mem[idx]  = slope;
                x0_seen[idx] = 1'b1;
                r.position   = apply_increment(longint'(pos), slope < 0,
                                   scale_by_dt(magnitude_of(longint'(slope)), 17));
                r.full_step  = 1'b0;
            end
            OP_STAGE2: begin
                k2_mem[idx]  = slope;
                k2_seen[idx] = 1'b1;
                r.position   = apply_increment(longint'(x0_mem[idx]), slope < 0,
                                   scale_by_dt(magnitude_of(longint'(slope)), 17));
                r.full_step  = 1'b0;
            end
            OP_STAGE3: begin
                k3_mem[idx]  = slope;
                k3_seen[idx] = 1'b1;
                r.position   = apply_increment(longint'(x0_mem[idx]), slope < 0,
                                   scale_by_dt(magnitude_of(longint'(slope)), 16));
            end
            OP_STAGE4: begin
                sum = longint'(k1_mem[idx]) + 2 * longint'(k2_mem[idx])
                    + 2 * longint'(k3_mem[idx]) + longint'(slope);
                r.position = apply_increment(longint'(x0_mem[idx]), sum < 0,
                                 sixth_by_dt(magnitude_of(sum)));
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] r;
        case ($urandom_range(0, 9))
            0: r = VAL_MAX;
            1: r = VAL_MIN;
            2: r = VAL_W'($urandom_range(0, 7)) - VAL_W'(4);
            3, 4, 5: r = VAL_W'($urandom_range(0, 1 << 21)) - VAL_W'(1 << 20);
            default: r = VAL_W'($urandom);
        endcase
        return r;
    endfunction

    // stages 2 and 3 need a saved start, stage 4 all three slopes
    function automatic logic [2:0] legal_op(input logic [2:0] op, input logic [IDX_W-1:0] idx);
        if ((op == OP_STAGE2 || op == OP_STAGE3) && !x0_seen[idx]) return OP_STAGE1;
        if (op == OP_STAGE4 && !(x0_seen[idx] && k2_seen[idx] && k3_seen[idx]))
            return OP_STAGE1;
        return op;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        // keep the log short on a badly broken build
        if (error_count <= REPORT_CAP) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic send_word(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                             input logic signed [VAL_W-1:0] slope,
                             input logic signed [VAL_W-1:0] pos);
        int unsigned gap;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_op            <= op;
        i_element_index <= idx;
        i_derivative    <= slope;
        i_position_in   <= pos;
        do @(posedge i_clk); while (o_stall);
        expected_updates.push_back(predict_update(op, idx, slope, pos));
        words_sent++;
    endtask

    // input idle, all results back, pipeline quiet
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_updates.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_time_step(input logic [DT_W-1:0] value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        dt_model    = value;
    endtask

    task automatic send_full_step(input logic [IDX_W-1:0] idx);
        for (int s = 0; s < 4; s++) begin
            send_word(OP_STAGE1 + 3'(s), idx, pick_value(), pick_value());
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_passthrough_ops();
        logic [2:0] op;
        for (int code = 0; code < 8; code++) begin
            op = 3'(code);
            if (op != OP_STAGE1 && op != OP_STAGE2 && op != OP_STAGE3 && op != OP_STAGE4) begin
                send_word(op, code[0] ? {IDX_W{1'b1}} : '0,
                          code[0] ? VAL_MIN : VAL_MAX, code[1] ? VAL_MIN : VAL_MAX);
            end
        end
    endtask

    task automatic test_saturation();
        send_word(OP_STAGE1, '0, VAL_MAX, VAL_MAX);
        send_word(OP_STAGE2, '0, VAL_MAX, VAL_MIN);
        send_word(OP_STAGE3, '0, VAL_MAX, VAL_MIN);
        send_word(OP_STAGE4, '0, VAL_MAX, VAL_MIN);
        send_word(OP_STAGE1, {IDX_W{1'b1}}, VAL_MIN, VAL_MIN);
        send_word(OP_STAGE3, {IDX_W{1'b1}}, VAL_MIN, VAL_MAX);
    endtask

    // same element on consecutive cycles through all four stages
    task automatic test_back_to_back_stages();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        send_full_step(IDX_W'(3));
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // dt = 1.0 and a one-code slope gives exactly half a code
    task automatic test_rounding_ties();
        send_word(OP_STAGE1, IDX_W'(7), VAL_W'(1), '0);
        send_word(OP_STAGE1, IDX_W'(8), -VAL_W'(1), '0);
    endtask

    task automatic test_time_step_extremes();
        write_time_step('0);
        send_full_step(IDX_W'(20));
        write_time_step(DT_MAX);
        send_full_step(IDX_W'(21));
    endtask

    task automatic test_random_steps();
        int unsigned      phase_end;
        int unsigned      count;
        logic [DT_W-1:0]  dt_value;
        logic [IDX_W-1:0] idx_list [8];
        logic [IDX_W-1:0] idx;
        logic [2:0]       op;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: dt_value = DT_RESET;
                1: dt_value = DT_W'($urandom_range(1, 1 << 18));
                2: dt_value = DT_W'($urandom);
                3: dt_value = DT_MAX;
                4: dt_value = DT_W'($urandom_range(1, 16));
                default: dt_value = DT_W'($urandom);
            endcase
            write_time_step(dt_value);
            phase_end = words_sent + RANDOM_WORDS / PHASES;
            while (words_sent < phase_end) begin
                src_gaps_on    = ($urandom_range(0, 3) != 0);
                sink_stalls_on = ($urandom_range(0, 3) != 0);
                count = $urandom_range(1, 8);
                for (int i = 0; i < count; i++) begin
                    // neighbors or repeats now and then to stress the element stores
                    case ($urandom_range(0, 3))
                        0: idx_list[i] = (i == 0) ? IDX_W'($urandom) : idx_list[i-1];
                        1: idx_list[i] = (i == 0) ? IDX_W'($urandom) : idx_list[i-1] + 1'b1;
                        default: idx_list[i] = IDX_W'($urandom);
                    endcase
                end
                if ($urandom_range(0, 9) < 7) begin
                    if ($urandom_range(0, 1) == 0) begin
                        // stage by stage across the element group
                        for (int s = 0; s < 4; s++) begin
                            for (int i = 0; i < count; i++) begin
                                send_word(OP_STAGE1 + 3'(s), idx_list[i],
                                          pick_value(), pick_value());
                            end
                        end
                    end else begin
                        for (int i = 0; i < count; i++) send_full_step(idx_list[i]);
                    end
                end else begin
                    // noise and broken sequences on the same group
                    for (int i = 0; i < 2 * count; i++) begin
                        idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom)
                                                           : idx_list[$urandom_range(0, count - 1)];
                        op  = legal_op(3'($urandom_range(0, 7)), idx);
                        send_word(op, idx, pick_value(), pick_value());
                    end
                end
            end
        end
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
            if (sink_stalls_on && $urandom_range(0, 2) == 0) begin
                stall_left <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_stage_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_updates.size() == 0) begin
                report_mismatch($sformatf("unexpected word pos=%h full=%b",
                                          o_position_out, o_full_step));
            end else begin
                want = expected_updates.pop_front();
                if (o_position_out !== want.position) begin
                    report_mismatch($sformatf("op %0d elem %0d position %h, want %h",
                                              want.op, want.index, o_position_out,
                                              want.position));
                end
                if (o_full_step !== want.full_step) begin
                    report_mismatch($sformatf("op %0d elem %0d full_step %b, want %b",
                                              want.op, want.index, o_full_step,
                                              want.full_step));
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("rk4_ode_stage_update_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_op            = '0;
        i_element_index = '0;
        i_derivative    = '0;
        i_position_in   = '0;
        dt_model        = DT_RESET;
        for (int i = 0; i < DEPTH; i++) begin
            x0_mem[i]  = '0;
            k1_mem[i]  = '0;
            k2_mem[i]  = '0;
            k3_mem[i]  = '0;
            x0_seen[i] = 1'b0;
            k2_seen[i] = 1'b0;
            k3_seen[i] = 1'b0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_passthrough_ops();
        test_saturation();
        test_back_to_back_stages();
        test_rounding_ties();
        test_time_step_extremes();
        test_random_steps();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_updates.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("rk4_ode_stage_update_unit verification clean");
        end else begin
            $display("rk4_ode_stage_update_unit verification failed");
        end
        $finish;
    end

endmodule
